>>> rtl/i2af_pkg.sv
// ----------------------------------------------------------------------------
// i2af_pkg
// Shared types, codes and character constants of the integer-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
package i2af_pkg;

   localparam int MAX_CHARS_DEF = 64;   // default character budget per number
   localparam int MAG_W         = 64;   // operand magnitude width
   localparam int BCD_DIGITS    = 20;   // decimal digits of a 64-bit value
   localparam int BCD_W         = BCD_DIGITS * 4;
   localparam int DD_CNT_W      = $clog2(MAG_W);
   localparam int BUF_AW        = 7;    // digit and comma buffer address
   localparam int BUF_DEPTH     = 2 ** BUF_AW;
   localparam int LEN_W         = 7;    // body length, pad width
   localparam int TOT_W         = 8;    // body plus padding plus prefix

   // conversion kinds
   localparam logic [2:0] KIND_DEC    = 3'd0;
   localparam logic [2:0] KIND_HEX_LO = 3'd1;
   localparam logic [2:0] KIND_HEX_UP = 3'd2;
   localparam logic [2:0] KIND_PTR    = 3'd3;
   localparam logic [2:0] KIND_OCT    = 3'd4;
   localparam logic [2:0] KIND_BIN    = 3'd5;

   // operand sizes
   localparam logic [2:0] SIZE_INT   = 3'd0;
   localparam logic [2:0] SIZE_BYTE  = 3'd1;
   localparam logic [2:0] SIZE_SHORT = 3'd2;
   localparam logic [2:0] SIZE_LONG  = 3'd3;
   localparam logic [2:0] SIZE_VLONG = 3'd4;

   // characters
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] PREFIX_OFS = 8'd23;   // 'a' + 23 is 'x'

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   // one classified number, handed from front to back
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      radix_type        radix;
      logic             upper;
      logic             commas;
      logic             zpad_en;
      logic [LEN_W-1:0] pad_width;
      logic [1:0]       pre_len;
      logic             neg;
   } job_type;

   function automatic logic [7:0] letter_base(input logic upper);
      letter_base = upper ? CH_UPPER_A : CH_LOWER_A;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      if (d < 4'd10) begin
         digit_char = CH_ZERO + {4'd0, d};
      end else begin
         digit_char = letter_base(upper) + {4'd0, d} - 8'd10;
      end
   endfunction

endpackage

>>> rtl/i2af_front.sv
// ----------------------------------------------------------------------------
// i2af_front
// Takes a request, registers it, cuts the operand to its size, takes
// the magnitude and classifies radix, padding and prefix for the back end.
// ----------------------------------------------------------------------------
module i2af_front
   import i2af_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [63:0]      req_value,
   input  logic [2:0]       req_conversion_kind,
   input  logic [2:0]       req_size_select,
   input  logic             req_unsigned_mode,
   input  logic             req_group_commas,
   input  logic             req_zero_pad,
   input  logic             req_left_align,
   input  logic             req_precision_given,
   input  logic             req_alternate_form,
   input  logic [6:0]       req_pad_width,
   input  logic             csr_we,
   input  logic             csr_data,
   input  logic             q_full,
   output logic             q_push,
   output job_type          q_data
);

   logic             in_valid_ff, in_valid_in;
   logic             long64_ff;
   logic [63:0]      value_ff;
   logic [2:0]       kind_ff;
   logic [2:0]       size_ff;
   logic             unsig_ff, commas_ff, zpad_ff, left_ff, prec_ff, alt_ff;
   logic [6:0]       pw_ff;
   logic             accept;

   radix_type        radix;
   logic [MAG_W-1:0] mask;
   logic [MAG_W-1:0] masked;
   logic             sign_bit;
   logic             neg;

   assign busy        = in_valid_ff & q_full;
   assign accept      = start & ~busy;
   assign q_push      = in_valid_ff & ~q_full;
   assign in_valid_in = accept | (in_valid_ff & q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         long64_ff   <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            long64_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff  <= req_value;
         kind_ff   <= req_conversion_kind;
         size_ff   <= req_size_select;
         unsig_ff  <= req_unsigned_mode;
         commas_ff <= req_group_commas;
         zpad_ff   <= req_zero_pad;
         left_ff   <= req_left_align;
         prec_ff   <= req_precision_given;
         alt_ff    <= req_alternate_form;
         pw_ff     <= req_pad_width;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_HEX_LO, KIND_HEX_UP, KIND_PTR: radix = RADIX_HEX;
         KIND_OCT:                           radix = RADIX_OCT;
         KIND_BIN:                           radix = RADIX_BIN;
         default:                            radix = RADIX_DEC;
      endcase

      case (size_ff)
         SIZE_BYTE: begin
            mask     = {{(MAG_W-8){1'b0}}, {8{1'b1}}};
            sign_bit = value_ff[7];
         end
         SIZE_SHORT: begin
            mask     = {{(MAG_W-16){1'b0}}, {16{1'b1}}};
            sign_bit = value_ff[15];
         end
         SIZE_LONG: begin
            if (long64_ff) begin
               mask     = {MAG_W{1'b1}};
               sign_bit = value_ff[63];
            end else begin
               mask     = {{(MAG_W-32){1'b0}}, {32{1'b1}}};
               sign_bit = value_ff[31];
            end
         end
         SIZE_VLONG: begin
            mask     = {MAG_W{1'b1}};
            sign_bit = value_ff[63];
         end
         default: begin
            mask     = {{(MAG_W-32){1'b0}}, {32{1'b1}}};
            sign_bit = value_ff[31];
         end
      endcase

      masked = value_ff & mask;
      neg    = sign_bit & ~unsig_ff & (radix != RADIX_HEX);

      q_data.mag       = neg ? ((~masked + {{(MAG_W-1){1'b0}}, 1'b1}) & mask) : masked;
      q_data.radix     = radix;
      q_data.upper     = (kind_ff == KIND_HEX_UP);
      q_data.commas    = commas_ff;
      q_data.zpad_en   = zpad_ff & ~left_ff & ~prec_ff;
      q_data.pad_width = pw_ff;
      q_data.neg       = neg;
      if (alt_ff && radix == RADIX_HEX) begin
         q_data.pre_len = 2'd2;
      end else if (alt_ff && radix == RADIX_OCT) begin
         q_data.pre_len = 2'd1;
      end else begin
         q_data.pre_len = 2'd0;
      end
   end

endmodule

>>> rtl/i2af_queue.sv
// ----------------------------------------------------------------------------
// i2af_queue
// Two-entry queue of classified numbers between front and back.
// ----------------------------------------------------------------------------
module i2af_queue
   import i2af_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    not_empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/i2af_back.sv
// ----------------------------------------------------------------------------
// i2af_back
// Converts one magnitude to digits least significant first into a character
// buffer (double dabble first for decimal), then emits prefix, pad zeros and
// the buffer most significant first, one character a cycle.
// ----------------------------------------------------------------------------
module i2af_back
   import i2af_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char,
   output logic       rsp_is_negative,
   output logic       rsp_truncated
);

   localparam int P_W = $clog2(MAX_CHARS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_BCD  = 5'b00010,
      ST_GEN  = 5'b00100,
      ST_SIZE = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   job_type               job_ff;
   logic [MAG_W-1:0]      src_ff;
   logic [BCD_W-1:0]      rem_ff;
   logic [DD_CNT_W-1:0]   cnt_ff;
   logic [1:0]            grp_ff;
   logic [BUF_AW-1:0]     wptr_ff;
   logic [LEN_W-1:0]      padded_ff;
   logic                  trunc_ff;
   logic [P_W-1:0]        p_ff;

   logic [7:0]            char_mem [BUF_DEPTH];
   logic                  mem_we;
   logic [7:0]            mem_wdata;
   logic [7:0]            rd_ff;

   logic                  o_valid_ff;
   logic                  o_body_ff, o_last_ff, o_neg_ff, o_trunc_ff;
   logic [7:0]            o_ch_ff;

   logic [BCD_W-1:0]      dabbled;
   logic [3:0]            digit;
   logic [BCD_W-1:0]      rem_shift;
   logic                  comma_now;
   logic [LEN_W-1:0]      padded;
   logic [TOT_W-1:0]      total;
   logic [TOT_W-1:0]      emit_cnt;
   logic                  trunc;
   logic [TOT_W-1:0]      pe;
   logic                  in_body, in_pad;
   logic [7:0]            emit_ch;

   assign job_pop = (state_ff == ST_IDLE) & job_valid;

   always_comb begin
      for (int j = 0; j < BCD_DIGITS; j++) begin
         dabbled[4*j +: 4] = (rem_ff[4*j +: 4] >= 4'd5) ? rem_ff[4*j +: 4] + 4'd3
                                                        : rem_ff[4*j +: 4];
      end

      case (job_ff.radix)
         RADIX_BIN: begin
            digit     = {3'd0, rem_ff[0]};
            rem_shift = rem_ff >> 1;
         end
         RADIX_OCT: begin
            digit     = {1'b0, rem_ff[2:0]};
            rem_shift = rem_ff >> 3;
         end
         default: begin
            digit     = rem_ff[3:0];
            rem_shift = rem_ff >> 4;
         end
      endcase

      comma_now = job_ff.commas & (grp_ff == 2'd3);
      mem_we    = (state_ff == ST_GEN);
      mem_wdata = comma_now ? CH_COMMA : digit_char(digit, job_ff.upper);

      // pad zeros count toward the width, the prefix does not
      padded   = (job_ff.zpad_en && job_ff.pad_width > wptr_ff) ? job_ff.pad_width
                                                                : wptr_ff;
      total    = {1'b0, padded} + {{(TOT_W-2){1'b0}}, job_ff.pre_len};
      trunc    = total > TOT_W'(MAX_CHARS);
      emit_cnt = trunc ? TOT_W'(MAX_CHARS) : total;

      // position p counts from the rightmost character
      pe      = TOT_W'(p_ff);
      in_body = pe < {1'b0, wptr_ff};
      in_pad  = pe < {1'b0, padded_ff};
      if (in_pad) begin
         emit_ch = CH_ZERO;
      end else if (job_ff.radix == RADIX_HEX && pe == {1'b0, padded_ff}) begin
         emit_ch = letter_base(job_ff.upper) + PREFIX_OFS;
      end else begin
         emit_ch = CH_ZERO;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = (job.radix == RADIX_DEC) ? ST_BCD : ST_GEN;
            end
         end
         ST_BCD: begin
            if (cnt_ff == '0) begin
               state_in = ST_GEN;
            end
         end
         ST_GEN: begin
            if (!comma_now && rem_shift == '0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (p_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= (state_ff == ST_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_ff  <= job;
               src_ff  <= job.mag;
               rem_ff  <= (job.radix == RADIX_DEC) ? '0
                                                   : {{(BCD_W-MAG_W){1'b0}}, job.mag};
               cnt_ff  <= '1;
               grp_ff  <= 2'd0;
               wptr_ff <= '0;
            end
         end
         ST_BCD: begin
            rem_ff <= {dabbled[BCD_W-2:0], src_ff[MAG_W-1]};
            src_ff <= src_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_GEN: begin
            if (!comma_now) begin
               rem_ff <= rem_shift;
            end
            grp_ff  <= grp_ff + 2'd1;
            wptr_ff <= wptr_ff + 1'b1;
         end
         ST_SIZE: begin
            padded_ff <= padded;
            trunc_ff  <= trunc;
            p_ff      <= P_W'(emit_cnt - 1'b1);
         end
         ST_EMIT: begin
            p_ff <= p_ff - 1'b1;
         end
         default: begin
            p_ff <= p_ff;
         end
      endcase
   end

   // character buffer, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_mem[wptr_ff] <= mem_wdata;
      end
      rd_ff <= char_mem[BUF_AW'(p_ff)];
   end

   always_ff @(posedge clock) begin
      o_body_ff  <= in_body;
      o_ch_ff    <= emit_ch;
      o_last_ff  <= (p_ff == '0);
      o_neg_ff   <= job_ff.neg;
      o_trunc_ff <= trunc_ff;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_out_char    = o_body_ff ? rd_ff : o_ch_ff;
   assign rsp_last_char   = o_last_ff;
   assign rsp_is_negative = o_neg_ff;
   assign rsp_truncated   = o_trunc_ff;

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer per transaction as ASCII text, one character per
// result, most significant first.
//
//   channel   ports                         handshake
//   request   start, busy, req_*            taken when start & ~busy
//   result    rsp_valid, rsp_*              one-cycle strobe, cannot stall
//   config    csr_valid, csr_ready, csr_*   taken when csr_valid & csr_ready
//
// In the back end a decimal number first passes double dabble (one bit a
// cycle); then its digits plus commas are written into the character buffer
// and its characters (at most MAX_CHARS) are emitted, one a cycle.
// The front end and a two-entry queue accept up to three numbers ahead.
// Reset is synchronous and sets long operands to 64 bits; no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
   import i2af_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic [2:0]  req_conversion_kind,
   input  logic [2:0]  req_size_select,
   input  logic        req_unsigned_mode,
   input  logic        req_group_commas,
   input  logic        req_zero_pad,
   input  logic        req_left_align,
   input  logic        req_precision_given,
   input  logic        req_alternate_form,
   input  logic [6:0]  req_pad_width,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   output logic        rsp_is_negative,
   output logic        rsp_truncated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_long_is_64_bits
);

   job_type front_job;
   job_type back_job;
   logic    q_push, q_full, q_pop, q_not_empty;

   assign csr_ready = 1'b1;

   i2af_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value           (req_value),
      .req_conversion_kind (req_conversion_kind),
      .req_size_select     (req_size_select),
      .req_unsigned_mode   (req_unsigned_mode),
      .req_group_commas    (req_group_commas),
      .req_zero_pad        (req_zero_pad),
      .req_left_align      (req_left_align),
      .req_precision_given (req_precision_given),
      .req_alternate_form  (req_alternate_form),
      .req_pad_width       (req_pad_width),
      .csr_we              (csr_valid & csr_ready),
      .csr_data            (csr_long_is_64_bits),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_data              (front_job)
   );

   i2af_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (back_job),
      .not_empty (q_not_empty)
   );

   i2af_back #(
      .MAX_CHARS (MAX_CHARS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_not_empty),
      .job             (back_job),
      .job_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_is_negative (rsp_is_negative),
      .rsp_truncated   (rsp_truncated)
   );

endmodule
